// ----- design/rhc_pkg.sv -----
// rhc_pkg: widths, constants, sector codes and pipeline record for the RGB to HSV converter.
// No dependencies; imported by every design file.
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 6;
  localparam int SAT_BITS          = 12;

  localparam int HUE_BITS     = 9 + HUE_FRACTION_BITS;
  localparam int SAT_OUT_BITS = SAT_BITS + 1;
  localparam int HUE_SIXTH    = 60 << HUE_FRACTION_BITS;
  localparam int HUE_FULL     = 360 << HUE_FRACTION_BITS;

  // quotient bits: hue quotient reaches HUE_SIXTH, saturation reaches 2^SAT_BITS
  localparam int HQ_BITS = $clog2(HUE_SIXTH + 1);
  localparam int Q_BITS  = (HQ_BITS > SAT_OUT_BITS) ? HQ_BITS : SAT_OUT_BITS;
  localparam int NUM_W   = CHANNEL_BITS + Q_BITS;

  // two front stages, one cell per quotient bit, one output stage
  localparam int LATENCY = Q_BITS + 3;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic                    valid;
    sector_e                 sector;
    logic                    neg;
    logic                    achro;
    logic [CHANNEL_BITS-1:0] value;
    logic [CHANNEL_BITS-1:0] div_h;
    logic [CHANNEL_BITS-1:0] rem_h;
    logic [Q_BITS-1:0]       low_h;
    logic [Q_BITS-1:0]       quo_h;
    logic [CHANNEL_BITS-1:0] div_s;
    logic [CHANNEL_BITS-1:0] rem_s;
    logic [Q_BITS-1:0]       low_s;
    logic [Q_BITS-1:0]       quo_s;
  } cell_t;

endpackage

// ----- design/rhc_front.sv -----
// rhc_front: two input stages: max/min/sector selection, then dividend forming.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output cell_t                   cell_o
);

  logic                    valid_a_q;
  sector_e                 sector_a_q, sector_a_d;
  logic                    neg_a_q, neg_a_d;
  logic                    achro_a_q;
  logic [CHANNEL_BITS-1:0] max_a_q, delta_a_q, diff_a_q, diff_a_d;
  logic [CHANNEL_BITS-1:0] mx_rg, mn_rg, mx, mn;
  logic                    valid_b_q;
  cell_t                   cell_b_q, cell_b_d;
  logic [NUM_W-1:0]        num_h, num_s;

  always_comb begin
    mx_rg = (red_i > green_i) ? red_i : green_i;
    mn_rg = (red_i < green_i) ? red_i : green_i;
    mx    = (mx_rg > blue_i) ? mx_rg : blue_i;
    mn    = (mn_rg < blue_i) ? mn_rg : blue_i;
    if (red_i >= mx) begin
      sector_a_d = SEC_RED;
      neg_a_d    = green_i < blue_i;
      diff_a_d   = neg_a_d ? blue_i - green_i : green_i - blue_i;
    end else if (green_i >= mx) begin
      sector_a_d = SEC_GREEN;
      neg_a_d    = blue_i < red_i;
      diff_a_d   = neg_a_d ? red_i - blue_i : blue_i - red_i;
    end else begin
      sector_a_d = SEC_BLUE;
      neg_a_d    = red_i < green_i;
      diff_a_d   = neg_a_d ? green_i - red_i : red_i - green_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= take_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_a_q <= sector_a_d;
    neg_a_q    <= neg_a_d;
    achro_a_q  <= (mx == mn);
    max_a_q    <= mx;
    delta_a_q  <= mx - mn;
    diff_a_q   <= diff_a_d;
  end

  always_comb begin
    num_h = NUM_W'(diff_a_q) * NUM_W'(HUE_SIXTH);
    num_s = NUM_W'(delta_a_q) << SAT_BITS;
    cell_b_d        = '0;
    cell_b_d.sector = sector_a_q;
    cell_b_d.neg    = neg_a_q;
    cell_b_d.achro  = achro_a_q;
    cell_b_d.value  = max_a_q;
    cell_b_d.div_h  = delta_a_q;
    cell_b_d.rem_h  = num_h[NUM_W-1:Q_BITS];
    cell_b_d.low_h  = num_h[Q_BITS-1:0];
    cell_b_d.div_s  = max_a_q;
    cell_b_d.rem_s  = num_s[NUM_W-1:Q_BITS];
    cell_b_d.low_s  = num_s[Q_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    cell_b_q <= cell_b_d;
  end

  always_comb begin
    cell_o       = cell_b_q;
    cell_o.valid = valid_b_q;
  end

endmodule

// ----- design/rhc_div_cell.sv -----
// rhc_div_cell: one restoring division step for the hue and saturation lanes.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_cell import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic                  valid_q;
  cell_t                 cell_q, cell_d;
  logic [CHANNEL_BITS:0] trial_h, trial_s, sub_h, sub_s;
  logic                  ge_h, ge_s;

  always_comb begin
    trial_h = {cell_i.rem_h, cell_i.low_h[Q_BITS-1]};
    trial_s = {cell_i.rem_s, cell_i.low_s[Q_BITS-1]};
    sub_h   = trial_h - {1'b0, cell_i.div_h};
    sub_s   = trial_s - {1'b0, cell_i.div_s};
    ge_h    = trial_h >= {1'b0, cell_i.div_h};
    ge_s    = trial_s >= {1'b0, cell_i.div_s};
    cell_d       = cell_i;
    cell_d.rem_h = ge_h ? sub_h[CHANNEL_BITS-1:0] : trial_h[CHANNEL_BITS-1:0];
    cell_d.rem_s = ge_s ? sub_s[CHANNEL_BITS-1:0] : trial_s[CHANNEL_BITS-1:0];
    cell_d.low_h = {cell_i.low_h[Q_BITS-2:0], 1'b0};
    cell_d.low_s = {cell_i.low_s[Q_BITS-2:0], 1'b0};
    cell_d.quo_h = {cell_i.quo_h[Q_BITS-2:0], ge_h};
    cell_d.quo_s = {cell_i.quo_s[Q_BITS-2:0], ge_s};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

// ----- design/rhc_back.sv -----
// rhc_back: hue assembly from sector and quotient, output register and strobe.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_back import rhc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_t                   cell_i,
  output logic                    result_valid_o,
  output logic [HUE_BITS-1:0]     hue_o,
  output logic [SAT_OUT_BITS-1:0] saturation_o,
  output logic [CHANNEL_BITS-1:0] value_o,
  output logic                    achromatic_o
);

  logic                    valid_q;
  logic [HUE_BITS-1:0]     hue_q;
  logic [SAT_OUT_BITS-1:0] sat_q;
  logic [CHANNEL_BITS-1:0] value_q;
  logic                    achro_q;
  logic [HUE_BITS:0]       quo, base, hue_d, ceil_quo;

  always_comb begin
    quo      = (HUE_BITS + 1)'(cell_i.quo_h[HQ_BITS-1:0]);
    ceil_quo = quo + (HUE_BITS + 1)'(cell_i.rem_h != '0);
    case (cell_i.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = (HUE_BITS + 1)'(2 * HUE_SIXTH);
      SEC_BLUE:  base = (HUE_BITS + 1)'(4 * HUE_SIXTH);
      default:   base = '0;
    endcase
    if (cell_i.achro) begin
      hue_d = '0;
    end else if (!cell_i.neg) begin
      hue_d = base + quo;
    end else if (cell_i.sector == SEC_RED) begin
      hue_d = (quo == '0) ? '0 : (HUE_BITS + 1)'(HUE_FULL) - quo;
    end else begin
      hue_d = base - ceil_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= hue_d[HUE_BITS-1:0];
    sat_q   <= cell_i.achro ? '0 : cell_i.quo_s[SAT_OUT_BITS-1:0];
    value_q <= cell_i.value;
    achro_q <= cell_i.achro;
  end

  assign result_valid_o = valid_q;
  assign hue_o          = hue_q;
  assign saturation_o   = sat_q;
  assign value_o        = value_q;
  assign achromatic_o   = achro_q;

endmodule

// ----- design/rgb_to_hsv_converter.sv -----
// rgb_to_hsv_converter: top level, front stages, chain of division cells, output stage.
// Depends on rhc_pkg, rhc_front, rhc_div_cell, rhc_back.
//
//   channel  | signals                                      | transfer
//   ---------+----------------------------------------------+---------------------------
//   pixel in | start, busy, red_i, green_i, blue_i          | start high and busy low
//   result   | result_valid_o, hue_o, saturation_o, value_o,| result_valid_o high, one
//            | achromatic_o                                 | cycle, no back pressure
//
// One pixel per cycle while busy is low; each result passes after its transfer edge through
// two front stages, one division cell per quotient bit and one output stage. The chain of
// cells sets the latency; every cell takes a new pixel each cycle. busy is high only during
// reset and the cycle after; no stall exists.
`timescale 1ns / 1ps

module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    result_valid_o,
  output logic [HUE_BITS-1:0]     hue_o,
  output logic [SAT_OUT_BITS-1:0] saturation_o,
  output logic [CHANNEL_BITS-1:0] value_o,
  output logic                    achromatic_o
);

  logic  busy_q;
  cell_t chain [Q_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (start && !busy_q),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .cell_o  (chain[0])
  );

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  rhc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cell_i         (chain[Q_BITS]),
    .result_valid_o (result_valid_o),
    .hue_o          (hue_o),
    .saturation_o   (saturation_o),
    .value_o        (value_o),
    .achromatic_o   (achromatic_o)
  );

endmodule

// ----- design/rhc_checker.sv -----
// rhc_checker: port-level assertions for rgb_to_hsv_converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter.
`timescale 1ns / 1ps

module rhc_checker import rhc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    result_valid_o,
  input logic [HUE_BITS-1:0]     hue_o,
  input logic [SAT_OUT_BITS-1:0] saturation_o,
  input logic [CHANNEL_BITS-1:0] value_o,
  input logic                    achromatic_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY result_valid_o)
    else $error("no result strobe at transfer latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching transfer");

  a_achro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && achromatic_o |-> hue_o == '0 && saturation_o == '0)
    else $error("achromatic result with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> 32'(hue_o) < HUE_FULL)
    else $error("hue out of range");

  a_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !achromatic_o |-> saturation_o != '0 && value_o != '0)
    else $error("chromatic result with zero saturation or value");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .hue_o          (hue_o),
  .saturation_o   (saturation_o),
  .value_o        (value_o),
  .achromatic_o   (achromatic_o)
);

// ----- tb/rgb_to_hsv_converter_test.sv -----
// rgb_to_hsv_converter_test: self-checking bench for the RGB to HSV converter.
// Predicts hue, saturation, value and the achromatic flag per pixel and checks each result.
// Depends on rhc_pkg and rgb_to_hsv_converter.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_test;
  import rhc_pkg::*;

  localparam int RANDOM_PIXELS = 500;
  localparam int CYCLE_LIMIT   = 20000;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [SAT_OUT_BITS-1:0] sat;
    chan_t                   value;
    logic                    achro;
  } hsv_t;

  class hsv_tracker;
    hsv_t pending_hsv[$];
    int   mismatches;

    function automatic hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
      int      ri, gi, bi, mx, mn, delta, diff, hue;
      sector_e sec;
      hsv_t    res;
      ri = r;
      gi = g;
      bi = b;
      mx = (ri > gi) ? ri : gi;
      mx = (mx > bi) ? mx : bi;
      mn = (ri < gi) ? ri : gi;
      mn = (mn < bi) ? mn : bi;
      delta = mx - mn;
      res.value = chan_t'(mx);
      if (delta == 0) begin
        res.hue   = '0;
        res.sat   = '0;
        res.achro = 1'b1;
        return res;
      end
      res.sat   = SAT_OUT_BITS'((delta << SAT_BITS) / mx);
      res.achro = 1'b0;
      // red wins ties, then green
      if (ri >= mx) begin
        sec  = SEC_RED;
        diff = gi - bi;
      end else if (gi >= mx) begin
        sec  = SEC_GREEN;
        diff = bi - ri;
      end else begin
        sec  = SEC_BLUE;
        diff = ri - gi;
      end
      hue = (HUE_SIXTH * (2 * int'(sec) * delta + diff)) / delta;
      if (hue < 0) begin
        hue += HUE_FULL;
      end
      res.hue = HUE_BITS'(hue);
      return res;
    endfunction

    function void note_pixel(chan_t r, chan_t g, chan_t b);
      pending_hsv.push_back(predict_hsv(r, g, b));
    endfunction

    function void check_result(logic [HUE_BITS-1:0] hue, logic [SAT_OUT_BITS-1:0] sat,
                               chan_t value, logic achro);
      hsv_t exp_hsv;
      if (pending_hsv.size() == 0) begin
        $error("result with no pixel outstanding: hue %0d saturation %0d value %0d",
               hue, sat, value);
        mismatches++;
        return;
      end
      exp_hsv = pending_hsv.pop_front();
      if (hue !== exp_hsv.hue) begin
        $error("hue: expected %0d, actual %0d", exp_hsv.hue, hue);
        mismatches++;
      end
      if (sat !== exp_hsv.sat) begin
        $error("saturation: expected %0d, actual %0d", exp_hsv.sat, sat);
        mismatches++;
      end
      if (value !== exp_hsv.value) begin
        $error("value: expected %0d, actual %0d", exp_hsv.value, value);
        mismatches++;
      end
      if (achro !== exp_hsv.achro) begin
        $error("achromatic: expected %0d, actual %0d", exp_hsv.achro, achro);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  chan_t                   red_i;
  chan_t                   green_i;
  chan_t                   blue_i;
  logic                    result_valid_o;
  logic [HUE_BITS-1:0]     hue_o;
  logic [SAT_OUT_BITS-1:0] saturation_o;
  chan_t                   value_o;
  logic                    achromatic_o;

  hsv_tracker tracker;
  int         cycle_count;

  rgb_to_hsv_converter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .result_valid_o (result_valid_o),
    .hue_o          (hue_o),
    .saturation_o   (saturation_o),
    .value_o        (value_o),
    .achromatic_o   (achromatic_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        tracker.note_pixel(red_i, green_i, blue_i);
      end
      if (result_valid_o) begin
        tracker.check_result(hue_o, saturation_o, value_o, achromatic_o);
      end
    end
  end

  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 33) begin
      start   <= 1'b0;
      red_i   <= chan_t'($urandom);
      green_i <= chan_t'($urandom);
      blue_i  <= chan_t'($urandom);
      @(posedge clk_i);
    end
    start   <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    @(posedge clk_i);
    // hold until the transfer happens
    while (busy) begin
      @(posedge clk_i);
    end
  endtask

  task automatic random_pixel(output chan_t r, output chan_t g, output chan_t b);
    r = chan_t'($urandom);
    g = chan_t'($urandom);
    b = chan_t'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: b = r;
      default: ;
    endcase
  endtask

  initial begin
    chan_t r, g, b;
    logic [3*CHANNEL_BITS-1:0] directed[$];
    tracker     = new();
    cycle_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    directed = '{24'h000000, 24'hffffff, 24'h808080, 24'h010101, 24'hff0000, 24'h00ff00,
                 24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff, 24'h010000, 24'h000100,
                 24'h000001, 24'hff0001, 24'h010001, 24'h0100ff, 24'hfffefe, 24'hfeffff,
                 24'haa5500, 24'h55aaff, 24'h010203, 24'h030201, 24'h7f80ff, 24'hff7f80};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_pixel(directed[i][23:16], directed[i][15:8], directed[i][7:0], 1'b1);
    end
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b, !(i >= 150 && i < 300));
    end
    start <= 1'b0;
    while (tracker.pending_hsv.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
